>>> hdl/fcs_pkg.sv
// Shared types and constants for the framed command signal sequencer.
// Used by the front classifier, the word queue, the back sequencer and the top level.
package fcs_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h41;
    localparam logic [7:0] END_BYTE  = 8'h5A;
    localparam logic [7:0] CMD_F     = 8'h46;
    localparam logic [7:0] CMD_B     = 8'h42;
    localparam logic [7:0] CMD_L     = 8'h4C;
    localparam logic [7:0] CMD_R     = 8'h52;

    localparam logic [9:0] YELLOW_RESET     = 10'd100;
    localparam logic [9:0] GREEN_MAIN_RESET = 10'd300;
    localparam logic [9:0] GREEN_SIDE_RESET = 10'd200;

    localparam logic [1:0] REG_YELLOW     = 2'd0;
    localparam logic [1:0] REG_GREEN_MAIN = 2'd1;
    localparam logic [1:0] REG_GREEN_SIDE = 2'd2;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    localparam logic [3:0] ALL_RED = 4'hF;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
        logic       is_sync;
        logic       is_end;
        logic       cmd_known;
        logic [1:0] cmd_appr;
    } t_item;

    typedef struct packed {
        logic [3:0] grn;
        logic [3:0] yel;
        logic [3:0] red;
    } t_lamps;

    function automatic t_lamps lamps_for(input logic [1:0] appr, input logic green);
        t_lamps     l;
        logic [3:0] sel;
        sel   = 4'b0001 << appr;
        l.red = ALL_RED & ~sel;
        l.yel = green ? 4'b0000 : sel;
        l.grn = green ? sel : 4'b0000;
        return l;
    endfunction

endpackage

>>> hdl/fcs_front.sv
// Front stage: registers incoming words and classifies them (sync, end mark, command).
// Depends on fcs_pkg; feeds fcs_queue.
module fcs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  logic [7:0]     i_rx_byte,
    output logic           o_in_stall,
    input  logic           i_q_full,
    output logic           o_push,
    output fcs_pkg::t_item o_item
);
    import fcs_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item           = '0;
        n_item.is_tick   = i_req_type;
        n_item.data      = i_rx_byte;
        n_item.is_sync   = (i_rx_byte == SYNC_BYTE);
        n_item.is_end    = (i_rx_byte == END_BYTE);
        n_item.cmd_known = 1'b1;
        unique case (i_rx_byte)
            CMD_F:   n_item.cmd_appr = 2'd0;
            CMD_B:   n_item.cmd_appr = 2'd1;
            CMD_L:   n_item.cmd_appr = 2'd2;
            CMD_R:   n_item.cmd_appr = 2'd3;
            default: n_item.cmd_known = 1'b0;
        endcase
    end

    assign o_in_stall = r_valid & i_q_full;
    assign o_push     = r_valid & ~i_q_full;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_item <= n_item;
        end
    end

endmodule

>>> hdl/fcs_queue.sv
// Short FIFO of classified words between the front and the back sequencer.
// Depends on fcs_pkg for the word type and depth.
module fcs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fcs_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output fcs_pkg::t_item o_item
);
    import fcs_pkg::*;

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QAW:0]   r_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

>>> hdl/fcs_back.sv
// Back sequencer: frame parser, yellow/green phase timer, lamp state and output register.
// Depends on fcs_pkg; pops classified words from fcs_queue.
module fcs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  fcs_pkg::t_item i_item,
    output logic           o_pop,
    input  logic [9:0]     i_yellow_ticks,
    input  logic [9:0]     i_green_ticks_main,
    input  logic [9:0]     i_green_ticks_side,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [3:0]     o_red_lamps,
    output logic [3:0]     o_yellow_lamps,
    output logic [3:0]     o_green_lamps,
    output logic           o_busy_res
);
    import fcs_pkg::*;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_YELLOW = 2'd1;
    localparam logic [1:0] PH_GREEN  = 2'd2;

    localparam logic [2:0] POS_SYNC0 = 3'd0;
    localparam logic [2:0] POS_SYNC1 = 3'd1;
    localparam logic [2:0] POS_CMD   = 3'd2;
    localparam logic [2:0] POS_INV   = 3'd3;
    localparam logic [2:0] POS_END   = 3'd4;
    localparam logic [2:0] POS_SKIP  = 3'd5;

    logic [1:0] r_phase, n_phase;
    logic [2:0] r_pos, n_pos;
    logic [7:0] r_cmd, n_cmd;
    logic [9:0] r_cnt, n_cnt;
    logic [1:0] r_appr, n_appr;
    t_lamps     r_lamps, n_lamps;

    logic       r_out_valid;
    t_lamps     r_out_lamps;
    logic       r_out_busy;

    logic [9:0] w_len;
    logic       w_done;

    // Command decode of the stored command byte, registered when the byte is taken.
    logic       w_cmd_known;
    logic [1:0] w_cmd_appr;
    logic       r_cmd_known;
    logic [1:0] r_cmd_appr;

    assign w_cmd_known = r_cmd_known;
    assign w_cmd_appr  = r_cmd_appr;

    assign o_pop = ~i_empty & (~r_out_valid | ~i_out_stall);

    assign w_len  = (r_phase == PH_YELLOW) ? i_yellow_ticks
                  : ((r_appr == 2'd0) ? i_green_ticks_main : i_green_ticks_side);
    assign w_done = ({1'b0, r_cnt} + 11'd1) >= {1'b0, w_len};

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        n_appr  = r_appr;
        n_lamps = r_lamps;
        if (i_item.is_tick) begin
            if (r_phase != PH_IDLE) begin
                if (w_done) begin
                    n_cnt = '0;
                    if (r_phase == PH_YELLOW) begin
                        n_phase = PH_GREEN;
                        n_lamps = lamps_for(r_appr, 1'b1);
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_cnt = r_cnt + 10'd1;
                end
            end
        end else if (r_phase == PH_IDLE) begin
            unique case (r_pos)
                POS_SYNC0, POS_SYNC1: begin
                    n_pos = i_item.is_sync ? (r_pos + 3'd1) : POS_SYNC0;
                end
                POS_CMD: begin
                    n_cmd = i_item.data;
                    n_pos = POS_INV;
                end
                POS_INV: begin
                    // A bad inverse still swallows the next byte before hunting again.
                    n_pos = (i_item.data == ~r_cmd) ? POS_END : POS_SKIP;
                end
                POS_END: begin
                    n_pos = POS_SYNC0;
                    // Command classification was done on this word's own byte, so
                    // use the classification registered with the stored command.
                    if (i_item.is_end && w_cmd_known) begin
                        n_appr  = w_cmd_appr;
                        n_lamps = lamps_for(w_cmd_appr, 1'b0);
                        n_phase = PH_YELLOW;
                        n_cnt   = '0;
                    end
                end
                default: n_pos = POS_SYNC0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pos       <= POS_SYNC0;
            r_cmd       <= '0;
            r_cnt       <= '0;
            r_appr      <= '0;
            r_lamps     <= '{grn: 4'b0000, yel: 4'b0000, red: ALL_RED};
            r_cmd_known <= 1'b0;
            r_cmd_appr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_cmd   <= n_cmd;
                r_cnt   <= n_cnt;
                r_appr  <= n_appr;
                r_lamps <= n_lamps;
                if (!i_item.is_tick && r_phase == PH_IDLE && r_pos == POS_CMD) begin
                    r_cmd_known <= i_item.cmd_known;
                    r_cmd_appr  <= i_item.cmd_appr;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_lamps <= n_lamps;
            r_out_busy  <= (n_phase != PH_IDLE);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red_lamps    = r_out_lamps.red;
    assign o_yellow_lamps = r_out_lamps.yel;
    assign o_green_lamps  = r_out_lamps.grn;
    assign o_busy_res     = r_out_busy;

endmodule

>>> hdl/framed_command_signal_sequencer.sv
// Top level of the framed command signal sequencer: config registers, front, queue, back.
// Depends on fcs_pkg, fcs_front, fcs_queue and fcs_back.
//
// Each input word is a serial byte or a 10 ms tick, and each produces exactly one
// result word with the lamp pattern and busy flag after it. A framed command
// 'A','A',cmd,~cmd,'Z' with cmd F/B/L/R runs yellow then green on approach 1..4;
// bytes arriving during a timed phase are dropped. The block takes one word per
// clock and returns one per clock when the output is not stalled; a word passes a
// front register, a 4-word queue and the sequencer's output register. A stalled
// output backs up into the queue; once it is full the input stalls as well.
// Config registers are written through a plain write port and must only change
// while the block is idle.
module framed_command_signal_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_req_type,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [3:0] o_red_lamps,
    output logic [3:0] o_yellow_lamps,
    output logic [3:0] o_green_lamps,
    output logic       o_busy_res,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [9:0] i_cfg_data
);
    import fcs_pkg::*;

    logic [9:0] r_yellow_ticks;
    logic [9:0] r_green_ticks_main;
    logic [9:0] r_green_ticks_side;

    logic  w_push, w_pop, w_full, w_empty;
    t_item w_front_item, w_q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yellow_ticks     <= YELLOW_RESET;
            r_green_ticks_main <= GREEN_MAIN_RESET;
            r_green_ticks_side <= GREEN_SIDE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_YELLOW:     r_yellow_ticks     <= i_cfg_data;
                REG_GREEN_MAIN: r_green_ticks_main <= i_cfg_data;
                REG_GREEN_SIDE: r_green_ticks_side <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .o_in_stall (o_in_stall),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_item     (w_front_item)
    );

    fcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_q_item)
    );

    fcs_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_empty            (w_empty),
        .i_item             (w_q_item),
        .o_pop              (w_pop),
        .i_yellow_ticks     (r_yellow_ticks),
        .i_green_ticks_main (r_green_ticks_main),
        .i_green_ticks_side (r_green_ticks_side),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_red_lamps        (o_red_lamps),
        .o_yellow_lamps     (o_yellow_lamps),
        .o_green_lamps      (o_green_lamps),
        .o_busy_res         (o_busy_res)
    );

    // Never push into a full queue and never pop an empty one.
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full) && !(w_pop && w_empty))
        else $error("queue overflow or underflow");

    // A result never lights yellow and green together, nor red where another lamp is on.
    a_lamp_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_yellow_lamps & o_green_lamps) == 4'b0000)
                        && ((o_red_lamps & (o_yellow_lamps | o_green_lamps)) == 4'b0000)
                        && $onehot0(o_yellow_lamps | o_green_lamps))
        else $error("conflicting lamp pattern");

    // Yellow is only shown during a timed phase.
    a_yellow_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_yellow_lamps != 4'b0000)) |-> o_busy_res)
        else $error("yellow lamp while not busy");

endmodule
